@@ rtl/core/ugnb_pkg.sv @@
// Package for the uniform grid binning block: constants, codes and the
// controller/datapath command and status structs. No dependencies.
`default_nettype none
package ugnb_pkg;
  localparam int GRID_COLUMNS_DEF  = 16;
  localparam int GRID_ROWS_DEF     = 16;
  localparam int CELL_CAPACITY_DEF = 8;
  localparam int ID_WIDTH_DEF      = 10;
  localparam int MAX_RESULTS       = 32;
  localparam int CFG_W             = 15;
  localparam int POS_W             = 16;
  localparam int PID_W             = 10;
  localparam int CNT_W             = 6;
  // Numerator is 2*pos + scene +- cell: fits in 19 signed bits.
  localparam int NUM_W             = 19;
  localparam int DEN_W             = 17;
  localparam int QUO_W             = 19;

  localparam logic [1:0] MODE_CLEAR = 2'd0;
  localparam logic [1:0] MODE_REG   = 2'd1;
  localparam logic [1:0] MODE_QUERY = 2'd2;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_OUT  = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  localparam logic [1:0] CFG_WIDTH  = 2'd0;
  localparam logic [1:0] CFG_HEIGHT = 2'd1;
  localparam logic [1:0] CFG_CELL   = 2'd2;

  typedef struct packed {
    logic       load;      // latch input item
    logic       div_start; // begin x/y division for corner in corner field
    logic [1:0] corner;
    logic       off_en;    // add the half-cell corner offsets (queries only)
    logic       clr_step;  // clear one cell count
    logic       clr_start;
    logic       reg_write; // store id and bump count
    logic       scan_start; // begin scanning current cell
    logic       rd_step;   // issue bucket read, advance slot
  } ugnb_cmd_t;

  typedef struct packed {
    logic div_done;
    logic cell_ok;
    logic cell_full;
    logic clr_done;
    logic scan_more;  // slot below fill remains
  } ugnb_sts_t;
endpackage
`default_nettype wire

@@ rtl/core/ugnb_datapath.sv @@
// Datapath: configuration registers, restoring dividers, fill counts and the
// bucket memory. Depends on ugnb_pkg.
`default_nettype none
module ugnb_datapath #(
  parameter int GRID_COLUMNS  = ugnb_pkg::GRID_COLUMNS_DEF,
  parameter int GRID_ROWS     = ugnb_pkg::GRID_ROWS_DEF,
  parameter int CELL_CAPACITY = ugnb_pkg::CELL_CAPACITY_DEF,
  parameter int ID_WIDTH      = ugnb_pkg::ID_WIDTH_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_valid,
  input  wire logic [1:0]                    cfg_index,
  input  wire logic [ugnb_pkg::CFG_W-1:0]    cfg_data,
  input  wire logic signed [ugnb_pkg::POS_W-1:0] in_pos_x,
  input  wire logic signed [ugnb_pkg::POS_W-1:0] in_pos_y,
  input  wire logic [ugnb_pkg::PID_W-1:0]    in_particle_id,
  input  wire ugnb_pkg::ugnb_cmd_t           cmd,
  output ugnb_pkg::ugnb_sts_t                sts,
  output logic [ID_WIDTH-1:0]                rd_id
);
  import ugnb_pkg::*;
  localparam int CELLS = GRID_COLUMNS * GRID_ROWS;
  localparam int CW    = $clog2(CELLS);
  localparam int SW    = (CELL_CAPACITY > 1) ? $clog2(CELL_CAPACITY) : 1;
  localparam int FW    = $clog2(CELL_CAPACITY + 1);
  localparam int DC_W  = $clog2(QUO_W + 1);

  logic [CFG_W-1:0] width_r, height_r, cell_r;
  logic signed [POS_W-1:0] px_r, py_r;
  logic [ID_WIDTH-1:0] pid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= CFG_W'(512);
      height_r <= CFG_W'(512);
      cell_r   <= CFG_W'(36);
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_WIDTH:  width_r  <= cfg_data;
        CFG_HEIGHT: height_r <= cfg_data;
        CFG_CELL:   cell_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      px_r  <= in_pos_x;
      py_r  <= in_pos_y;
      pid_r <= in_particle_id[ID_WIDTH-1:0];
    end
  end

  // Floored division of both numerators by 2*cell, one quotient bit per cycle.
  logic [CFG_W-1:0] cs;
  logic signed [NUM_W-1:0] offx, offy, nx, ny;
  logic [DEN_W-1:0] den_r;
  logic [NUM_W-1:0] ax_r, ay_r;       // magnitudes, shifted out as quotient forms
  logic [DEN_W:0]   rx_r, ry_r;
  logic             negx_r, negy_r;
  logic [DC_W-1:0]  dcnt_r;
  logic             busy_r;
  logic             rd_ok_r;
  logic [DEN_W:0]   trx, try_;

  always_comb begin
    cs = (cell_r == '0) ? CFG_W'(1) : cell_r;
    if (cmd.off_en) begin
      offx = cmd.corner[1] ? -$signed({4'b0, cs}) : $signed({4'b0, cs});
      offy = (cmd.corner == 2'd0 || cmd.corner == 2'd3) ? $signed({4'b0, cs})
                                                        : -$signed({4'b0, cs});
    end else begin
      offx = '0;
      offy = '0;
    end
    nx = NUM_W'($signed({px_r, 1'b0})) + $signed({4'b0, width_r});
    ny = NUM_W'($signed({py_r, 1'b0})) + $signed({4'b0, height_r});
    trx  = {rx_r[DEN_W-1:0], ax_r[NUM_W-1]};
    try_ = {ry_r[DEN_W-1:0], ay_r[NUM_W-1]};
  end

  logic signed [NUM_W-1:0] fx, fy;
  logic [QUO_W-1:0] qx, qy;
  always_comb begin
    fx = nx + offx;
    fy = ny + offy;
  end

  // For negative n, floor(n/d) = -ceil(-n/d) = -((|n|+d-1)/d).
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      dcnt_r <= '0;
    end else if (cmd.div_start) begin
      busy_r <= 1'b1;
      dcnt_r <= DC_W'(QUO_W);
      den_r  <= {1'b0, cs, 1'b0};
      negx_r <= fx[NUM_W-1];
      negy_r <= fy[NUM_W-1];
      ax_r   <= fx[NUM_W-1] ? NUM_W'(-fx + $signed({3'b0, cs, 1'b0}) - 1) : fx;
      ay_r   <= fy[NUM_W-1] ? NUM_W'(-fy + $signed({3'b0, cs, 1'b0}) - 1) : fy;
      rx_r   <= '0;
      ry_r   <= '0;
    end else if (busy_r) begin
      if (trx >= {1'b0, den_r}) begin
        rx_r <= trx - {1'b0, den_r};
        ax_r <= {ax_r[NUM_W-2:0], 1'b1};
      end else begin
        rx_r <= trx;
        ax_r <= {ax_r[NUM_W-2:0], 1'b0};
      end
      if (try_ >= {1'b0, den_r}) begin
        ry_r <= try_ - {1'b0, den_r};
        ay_r <= {ay_r[NUM_W-2:0], 1'b1};
      end else begin
        ry_r <= try_;
        ay_r <= {ay_r[NUM_W-2:0], 1'b0};
      end
      dcnt_r <= dcnt_r - 1'b1;
      if (dcnt_r == DC_W'(1)) busy_r <= 1'b0;
    end
  end

  // The fill count read is registered, so it lands in the cycle after the final
  // quotient; the result is reported done only once the count of the new cell is in fill_q.
  always_ff @(posedge clk) begin
    if (!rst_n) rd_ok_r <= 1'b0;
    else rd_ok_r <= !busy_r && !cmd.div_start;
  end

  // Linear cell = cx + cy*COLUMNS, checked in a wide signed range.
  localparam int LW = QUO_W + 10;
  logic signed [LW-1:0] cxs, cys, lin;
  logic [CW-1:0] cell_idx;
  logic          ok;
  always_comb begin
    qx  = ax_r;
    qy  = ay_r;
    cxs = negx_r ? -$signed(LW'(qx)) : $signed(LW'(qx));
    cys = negy_r ? -$signed(LW'(qy)) : $signed(LW'(qy));
    lin = cxs + cys * $signed(LW'(GRID_COLUMNS));
    ok  = (lin >= 0) && (lin < $signed(LW'(CELLS)));
    cell_idx = lin[CW-1:0];
  end

  // Fill counts: a memory with registered read, emptied by a sweep of one
  // entry per cycle after reset and on a clear.
  logic [FW-1:0] fill_mem [CELLS];
  logic [FW-1:0] fill_q;
  logic [CW:0]   clr_r;
  logic [CW-1:0] cell_r2;
  logic [SW-1:0] slot_r;

  always_ff @(posedge clk) begin
    if (!rst_n) clr_r <= '0;
    else if (cmd.clr_start) clr_r <= '0;
    else if (cmd.clr_step) clr_r <= clr_r + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (cmd.clr_step) fill_mem[clr_r[CW-1:0]] <= '0;
    else if (cmd.reg_write) fill_mem[cell_idx] <= fill_q + 1'b1;
    fill_q <= fill_mem[cell_idx];
  end

  // Bucket memory: one write or one read per cycle, registered read data.
  logic [ID_WIDTH-1:0] mem [CELLS*CELL_CAPACITY];
  localparam int AW = $clog2(CELLS*CELL_CAPACITY);
  logic [AW-1:0] waddr, raddr;
  logic [FW-1:0] scan_fill_r;
  always_comb begin
    waddr = AW'(cell_idx) * AW'(CELL_CAPACITY) + AW'(fill_q);
    raddr = AW'(cell_r2) * AW'(CELL_CAPACITY) + AW'(slot_r);
  end

  always_ff @(posedge clk) begin
    if (cmd.reg_write) mem[waddr] <= pid_r;
    if (cmd.rd_step) rd_id <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_start) begin
      cell_r2     <= cell_idx;
      slot_r      <= '0;
      scan_fill_r <= ok ? fill_q : '0;
    end else if (cmd.rd_step) begin
      slot_r <= slot_r + 1'b1;
      scan_fill_r <= scan_fill_r - 1'b1;
    end
  end

  always_comb begin
    sts.div_done  = rd_ok_r && !busy_r && !cmd.div_start;
    sts.cell_ok   = ok;
    sts.cell_full = fill_q >= FW'(CELL_CAPACITY);
    sts.clr_done  = clr_r == (CW+1)'(CELLS);
    sts.scan_more = scan_fill_r != '0;
  end
endmodule
`default_nettype wire

@@ rtl/core/ugnb_ctrl.sv @@
// Controller state machine: sequences clear, register and query items and
// drives the result register. Depends on ugnb_pkg.
`default_nettype none
module ugnb_ctrl #(
  parameter int ID_WIDTH = ugnb_pkg::ID_WIDTH_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire logic [1:0]                 in_mode,
  output ugnb_pkg::ugnb_cmd_t             cmd,
  input  wire ugnb_pkg::ugnb_sts_t        sts,
  input  wire logic [ID_WIDTH-1:0]        rd_id,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output logic [1:0]                      out_status,
  output logic [ugnb_pkg::PID_W-1:0]      out_neighbour_id,
  output logic                            out_found,
  output logic [ugnb_pkg::CNT_W-1:0]      out_neighbour_count,
  output logic                            out_last
);
  import ugnb_pkg::*;
  typedef enum logic [3:0] {
    S_INIT, S_IDLE, S_CLEAR, S_RDIV, S_RDEC, S_QDIV, S_QSCAN, S_QREAD, S_QEMIT,
    S_QNEXT, S_QEND, S_OUT
  } state_t;

  state_t state_r;
  logic [1:0] corner_r;
  logic [CNT_W-1:0] n_r;
  logic pend_r; // a read id waits in the output register
  logic [1:0] st_r;
  logic more;   // the current cell has ids left and the result limit is not hit

  // kick_r is set with the state change, so division starts as a division state begins.
  logic kick_r;

  always_comb begin
    more = sts.scan_more && (n_r != CNT_W'(MAX_RESULTS));
    cmd = '0;
    cmd.corner = corner_r;
    cmd.off_en = (state_r == S_QDIV);
    cmd.div_start = kick_r;
    in_ready = (state_r == S_IDLE) && !out_valid;
    if (in_valid && in_ready) begin
      cmd.load = 1'b1;
      cmd.clr_start = 1'b1;
    end
    unique case (state_r)
      S_INIT, S_CLEAR: cmd.clr_step = !sts.clr_done;
      S_RDEC: cmd.reg_write = sts.div_done && sts.cell_ok && !sts.cell_full;
      S_QSCAN: cmd.scan_start = sts.div_done;
      S_QREAD: cmd.rd_step = more && !pend_r && !out_valid;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
      out_valid <= 1'b0;
      kick_r <= 1'b0;
      corner_r <= '0;
      n_r <= '0;
      pend_r <= 1'b0;
    end else begin
      kick_r <= 1'b0;
      if (out_valid && out_ready) out_valid <= 1'b0;
      unique case (state_r)
        S_INIT: if (sts.clr_done) state_r <= S_IDLE;
        S_IDLE: if (in_valid && in_ready) begin
          corner_r <= '0;
          n_r <= '0;
          unique case (in_mode)
            MODE_CLEAR: state_r <= S_CLEAR;
            MODE_REG: begin state_r <= S_RDIV; kick_r <= 1'b1; end
            MODE_QUERY: begin state_r <= S_QDIV; kick_r <= 1'b1; end
            default: begin st_r <= ST_OK; state_r <= S_OUT; end
          endcase
        end
        S_CLEAR: if (sts.clr_done) begin st_r <= ST_OK; state_r <= S_OUT; end
        S_RDIV: state_r <= S_RDEC;
        S_RDEC: if (sts.div_done) begin
          st_r <= !sts.cell_ok ? ST_OUT : (sts.cell_full ? ST_FULL : ST_OK);
          state_r <= S_OUT;
        end
        S_OUT: begin
          out_valid <= 1'b1;
          out_status <= st_r;
          out_neighbour_id <= '0;
          out_found <= 1'b0;
          out_neighbour_count <= '0;
          out_last <= 1'b1;
          state_r <= S_IDLE;
        end
        S_QDIV: state_r <= S_QSCAN;
        S_QSCAN: if (sts.div_done) state_r <= S_QREAD;
        S_QREAD: begin
          // Another id follows, so the held one goes out without last.
          if (!more) state_r <= S_QNEXT;
          else if (pend_r) begin
            if (!out_valid) begin
              out_valid <= 1'b1;
              out_status <= ST_OK;
              out_found <= 1'b1;
              out_neighbour_count <= n_r;
              out_last <= 1'b0;
              pend_r <= 1'b0;
            end
          end else if (cmd.rd_step) state_r <= S_QEMIT;
        end
        S_QEMIT: begin
          // Hold the id until it is known whether more follow.
          pend_r <= 1'b1;
          n_r <= n_r + 1'b1;
          out_neighbour_id <= PID_W'(rd_id);
          state_r <= S_QREAD;
        end
        S_QNEXT: begin
          if (corner_r != 2'd3 && n_r != CNT_W'(MAX_RESULTS)) begin
            corner_r <= corner_r + 1'b1;
            kick_r <= 1'b1;
            state_r <= S_QDIV;
          end else state_r <= S_QEND;
        end
        S_QEND: if (!out_valid) begin
          out_valid <= 1'b1;
          out_status <= ST_OK;
          out_last <= 1'b1;
          out_found <= pend_r;
          out_neighbour_count <= n_r;
          if (!pend_r) out_neighbour_id <= '0;
          pend_r <= 1'b0;
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

@@ rtl/core/uniform_grid_neighbour_binning.sv @@
// Top level of the uniform grid binning block: joins controller and datapath.
// Depends on ugnb_pkg, ugnb_ctrl and ugnb_datapath.
//
// Usage: items enter on the in_ channel (valid/ready) with a mode, a signed
// Q8.8 position and an id. Clear, register and unused modes each give one
// result beat with out_last high. A query gives one beat per stored id of
// the four cells around the point (at most 32), out_last on the final one,
// or a single empty beat. The block takes one item at a time.
// A register item gives its beat once the 19-step restoring divider and the
// fill count read are done. A query runs division and lookup for each
// corner cell in turn and then reads out that cell's ids one by one, going
// on while the receiver keeps up. A clear sweeps every fill count, one per
// cycle, and then gives its beat. After reset the same sweep empties all
// cells before in_ready rises; the registers hold 512, 512 and 36.
// When the receiver stalls, the result register holds its beat and the
// sequencer waits. Configuration beats are always taken and act at once;
// write them only while no item is in flight.
`default_nettype none
module uniform_grid_neighbour_binning #(
  parameter int GRID_COLUMNS  = ugnb_pkg::GRID_COLUMNS_DEF,
  parameter int GRID_ROWS     = ugnb_pkg::GRID_ROWS_DEF,
  parameter int CELL_CAPACITY = ugnb_pkg::CELL_CAPACITY_DEF,
  parameter int ID_WIDTH      = ugnb_pkg::ID_WIDTH_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        cfg_valid,
  output logic                             cfg_ready,
  input  wire logic [1:0]                  cfg_index,
  input  wire logic [ugnb_pkg::CFG_W-1:0]  cfg_data,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic [1:0]                  in_mode,
  input  wire logic signed [ugnb_pkg::POS_W-1:0] in_pos_x,
  input  wire logic signed [ugnb_pkg::POS_W-1:0] in_pos_y,
  input  wire logic [ugnb_pkg::PID_W-1:0]  in_particle_id,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic [1:0]                       out_status,
  output logic [ugnb_pkg::PID_W-1:0]       out_neighbour_id,
  output logic                             out_found,
  output logic [ugnb_pkg::CNT_W-1:0]       out_neighbour_count,
  output logic                             out_last
);
  import ugnb_pkg::*;
  ugnb_cmd_t cmd;
  ugnb_sts_t sts;
  logic [ID_WIDTH-1:0] rd_id;

  assign cfg_ready = 1'b1;

  ugnb_datapath #(.GRID_COLUMNS(GRID_COLUMNS), .GRID_ROWS(GRID_ROWS),
    .CELL_CAPACITY(CELL_CAPACITY), .ID_WIDTH(ID_WIDTH)) u_dp (
    .clk, .rst_n, .cfg_valid, .cfg_index, .cfg_data,
    .in_pos_x, .in_pos_y, .in_particle_id, .cmd, .sts, .rd_id);

  ugnb_ctrl #(.ID_WIDTH(ID_WIDTH)) u_ctrl (
    .clk, .rst_n, .in_valid, .in_ready, .in_mode, .cmd, .sts, .rd_id,
    .out_valid, .out_ready, .out_status, .out_neighbour_id, .out_found,
    .out_neighbour_count, .out_last);

  a_no_input_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready) else $error("input taken while result pending");
  a_found_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_found) |-> out_neighbour_count != '0)
    else $error("found beat with zero count");
  a_status_query: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_found) |-> out_status == ST_OK)
    else $error("query beat with nonzero status");
endmodule
`default_nettype wire
